/* hdl/ria_pkg.sv */
`default_nettype none

package ria_pkg;

  // table geometry
  localparam int ID_SLOTS     = 64;
  localparam int PAYLOAD_BITS = 32;
  localparam int ID_W         = $clog2(ID_SLOTS);

  // fixed field widths on the channels
  localparam int ID_BITS      = 6;
  localparam int OUT_PAY_BITS = 32;

  // reserved identifier, never granted
  localparam logic [ID_W-1:0]    ID_INVALID     = ID_W'(ID_SLOTS - 1);
  localparam logic [ID_BITS-1:0] ID_INVALID_OUT = ID_BITS'(ID_SLOTS - 1);

  typedef logic [ID_W-1:0]         slot_idx_t;
  typedef logic [PAYLOAD_BITS-1:0] pay_t;
  typedef logic [ID_SLOTS-1:0]     slot_vec_t;

  typedef enum logic [1:0] {
    KIND_ATTACH     = 2'd0,
    KIND_DETACH     = 2'd1,
    KIND_EXIST      = 2'd2,
    KIND_DETACH_ALL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_OUT
  } state_t;

  // requests from the sequencer to the slot map
  typedef struct packed {
    logic      alloc;
    logic      clr;
    slot_idx_t clr_idx;
    slot_idx_t look_idx;
  } map_cmd_t;

  // answers of the slot map
  typedef struct packed {
    logic      alloc_ok;
    slot_idx_t alloc_idx;
    logic      first_ok;
    slot_idx_t first_idx;
    logic      more;
    logic      look_used;
  } map_stat_t;

  typedef struct packed {
    logic      ok;
    slot_idx_t idx;
  } pick_t;

  // lowest set bit of a slot vector
  function automatic pick_t lowest_set(slot_vec_t v);
    pick_t p;
    p = '0;
    for (int i = ID_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        p.ok  = 1'b1;
        p.idx = slot_idx_t'(i);
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

/* hdl/ria_in_if.sv */
`default_nettype none

interface ria_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [5:0]  task_id;
  logic [31:0] payload_in;

  modport source (output valid, kind, task_id, payload_in, input ready);
  modport sink   (input valid, kind, task_id, payload_in, output ready);
endinterface

`default_nettype wire

/* hdl/ria_out_if.sv */
`default_nettype none

interface ria_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  id_out;
  logic [31:0] payload_out;
  logic        found;
  logic        full_res;
  logic        last;

  modport source (output valid, id_out, payload_out, found, full_res, last, input ready);
  modport sink   (input valid, id_out, payload_out, found, full_res, last, output ready);
endinterface

`default_nettype wire

/* hdl/rotating_id_allocator_unit.sv */
`default_nettype none

// Round-robin tag allocator with 64 slots; identifier 63 is reserved as invalid. Used bits sit
// in flip-flops next to a rotating free-slot search, payload handles sit in a one-port-read
// RAM with a registered read port. One item is worked at a time: an attach gives its word
// the cycle after it is accepted, a detach or exist needs one RAM read first, and a detach
// all works a search, a RAM read and an output word for each stored entry, or a search and
// an output word alone on an empty table. There is a single output register. The RAM holds
// nothing at reset and its data is only used at slots whose used bit is set, so no clearing
// pass is needed.
module rotating_id_allocator_unit (
  input logic       clk,
  input logic       rst_n,
  ria_in_if.sink    in_ch,
  ria_out_if.source out_ch
);
  import ria_pkg::*;

  state_t    state_r, state_nxt;
  kind_t     kind_r, in_kind;
  logic      in_fire, out_fire;
  logic      tid_ok, hit;
  slot_idx_t look_idx;
  map_cmd_t  cmd;
  map_stat_t stat;

  logic      ram_we, ram_re;
  slot_idx_t ram_waddr, ram_raddr;
  pay_t      ram_wdata, ram_rdata;

  // pending word, completed after the RAM read
  logic [ID_BITS-1:0] id_r;
  logic               found_r;
  logic               last_r;

  // output register
  logic [ID_BITS-1:0]      out_id_r;
  logic [OUT_PAY_BITS-1:0] out_pay_r;
  logic                    out_found_r, out_full_r, out_last_r;

  assign in_kind  = kind_t'(in_ch.kind);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign tid_ok   = in_ch.task_id < ID_INVALID_OUT;
  assign look_idx = slot_idx_t'(in_ch.task_id);
  assign hit      = tid_ok && stat.look_used;

  ria_slot_map u_map (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .stat (stat)
  );

  ria_ram #(
    .DEPTH(ID_SLOTS),
    .WIDTH(PAYLOAD_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_kind) inside
            KIND_ATTACH:             state_nxt = ST_OUT;
            KIND_DETACH, KIND_EXIST: state_nxt = ST_READ;
            KIND_DETACH_ALL:         state_nxt = ST_SCAN;
            default:                 state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: state_nxt = stat.first_ok ? ST_READ : ST_OUT;
      ST_READ: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = (kind_r == KIND_DETACH_ALL && !last_r) ? ST_SCAN : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshakes, slot map requests and RAM access
  always_comb begin
    in_ch.ready  = (state_r == ST_IDLE);
    out_ch.valid = (state_r == ST_OUT);

    cmd.alloc    = in_fire && (in_kind == KIND_ATTACH);
    cmd.look_idx = look_idx;
    cmd.clr      = (in_fire && (in_kind == KIND_DETACH) && hit)
                   || ((state_r == ST_SCAN) && stat.first_ok);
    cmd.clr_idx  = (state_r == ST_SCAN) ? stat.first_idx : look_idx;

    ram_we    = cmd.alloc && stat.alloc_ok;
    ram_waddr = stat.alloc_idx;
    ram_wdata = PAYLOAD_BITS'(in_ch.payload_in);
    ram_re    = (in_fire && (in_kind == KIND_DETACH || in_kind == KIND_EXIST))
                || ((state_r == ST_SCAN) && stat.first_ok);
    ram_raddr = (state_r == ST_SCAN) ? stat.first_idx : look_idx;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= KIND_ATTACH;
      last_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        kind_r <= in_kind;
        last_r <= 1'b1;
      end else if (state_r == ST_SCAN && stat.first_ok) begin
        last_r <= !stat.more;
      end
    end
  end

  // pending word and output word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      id_r    <= in_ch.task_id;
      found_r <= hit;
      if (in_kind == KIND_ATTACH) begin
        out_id_r    <= stat.alloc_ok ? ID_BITS'(stat.alloc_idx) : ID_INVALID_OUT;
        out_pay_r   <= '0;
        out_found_r <= 1'b0;
        out_full_r  <= !stat.alloc_ok;
        out_last_r  <= 1'b1;
      end
    end else if (state_r == ST_SCAN) begin
      if (stat.first_ok) begin
        id_r    <= ID_BITS'(stat.first_idx);
        found_r <= 1'b1;
      end else begin
        // empty table
        out_id_r    <= ID_INVALID_OUT;
        out_pay_r   <= '0;
        out_found_r <= 1'b0;
        out_full_r  <= 1'b0;
        out_last_r  <= 1'b1;
      end
    end else if (state_r == ST_READ) begin
      out_id_r    <= id_r;
      out_pay_r   <= found_r ? OUT_PAY_BITS'(ram_rdata) : '0;
      out_found_r <= found_r;
      out_full_r  <= 1'b0;
      out_last_r  <= last_r;
    end
  end

  assign out_ch.id_out      = out_id_r;
  assign out_ch.payload_out = out_pay_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.full_res    = out_full_r;
  assign out_ch.last        = out_last_r;

  // a full answer always carries the invalid identifier and is never marked found
  a_full_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.full_res |-> out_ch.id_out == ID_INVALID_OUT && !out_ch.found)
    else $error("full answer with a granted identifier");

  // the allocator never grants the reserved identifier
  a_no_invalid_grant: assert property (@(posedge clk) disable iff (!rst_n)
    stat.alloc_ok |-> stat.alloc_idx != ID_INVALID)
    else $error("reserved identifier granted");

  // one item at a time: no new word taken while a result is shown
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input taken while result pending");

  // a drain word that is not last is followed by another scan
  a_drain_continue: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && kind_r == KIND_DETACH_ALL && !out_ch.last |=> state_r == ST_SCAN)
    else $error("drain stopped early");

endmodule

`default_nettype wire

/* hdl/ria_ram.sv */
`default_nettype none

module ria_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/ria_slot_map.sv */
`default_nettype none

module ria_slot_map (
  input  logic               clk,
  input  logic               rst_n,
  input  ria_pkg::map_cmd_t  cmd,
  output ria_pkg::map_stat_t stat
);
  import ria_pkg::*;

  slot_vec_t used_r, used_nxt;
  slot_idx_t cursor_r, cursor_nxt;
  slot_vec_t valid_m, above_m, free_v;
  pick_t     pick_hi, pick_lo, pick, first;

  // constant mask of grantable identifiers, and slots above the cursor
  always_comb begin
    for (int i = 0; i < ID_SLOTS; i++) begin
      valid_m[i] = (i < ID_SLOTS - 1);
      above_m[i] = (slot_idx_t'(i) > cursor_r);
    end
  end

  // rotating search for a free slot, wrapping to the bottom
  always_comb begin
    free_v  = ~used_r & valid_m;
    pick_hi = lowest_set(free_v & above_m);
    pick_lo = lowest_set(free_v);
    pick    = pick_hi.ok ? pick_hi : pick_lo;
  end

  // lowest used slot for the drain
  always_comb begin
    first = lowest_set(used_r);
  end

  always_comb begin
    stat.alloc_ok  = pick.ok;
    stat.alloc_idx = pick.idx;
    stat.first_ok  = first.ok;
    stat.first_idx = first.idx;
    stat.more      = |(used_r & ~(slot_vec_t'(1) << first.idx));
    stat.look_used = used_r[cmd.look_idx];
  end

  // used bits and cursor update
  always_comb begin
    used_nxt   = used_r;
    cursor_nxt = cursor_r;
    if (cmd.alloc && pick.ok) begin
      used_nxt[pick.idx] = 1'b1;
      cursor_nxt         = pick.idx;
    end
    if (cmd.clr) begin
      used_nxt[cmd.clr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      cursor_r <= '0;
    end else begin
      used_r   <= used_nxt;
      cursor_r <= cursor_nxt;
    end
  end

endmodule

`default_nettype wire

/* bench/tb_rotating_id_allocator_unit.sv */
module tb_rotating_id_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ria_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 120;
  localparam int TAIL_CYCLES = 30;

  // one request word as queued for the driver
  typedef struct {
    kind_t       kind;
    logic [5:0]  task_id;
    logic [31:0] payload;
    bit          aim;    // swap task_id for a live identifier when one exists
    bit          drain;  // hold off until every result word has come back
  } tag_req_t;

  // one result word as the allocator should return it
  typedef struct {
    logic [5:0]  id;
    logic [31:0] payload;
    logic        found;
    logic        full;
    logic        last;
  } tag_resp_t;

  logic clk;
  logic rst_n;

  ria_in_if  in_ch ();
  ria_out_if out_ch ();

  rotating_id_allocator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // tag table shadow
  slot_idx_t grant_ptr = '0;
  bit        slot_busy [ID_SLOTS] = '{default: 1'b0};
  pay_t      slot_handle [ID_SLOTS];

  tag_req_t  pending_reqs[$];
  tag_resp_t due_words[$];
  tag_req_t  on_bus;

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // update the shadow table with one accepted request and queue its result words
  function automatic void apply_to_tag_table(input tag_req_t r);
    slot_idx_t probe;
    bit        granted;
    int        live;
    int        emitted;
    case (r.kind)
      KIND_ATTACH: begin
        probe   = grant_ptr;
        granted = 1'b0;
        for (int i = 0; i < ID_SLOTS - 1; i++) begin
          if (!granted) begin
            // step past the reserved identifier back to zero
            probe = (int'(probe) + 1 >= ID_SLOTS - 1) ? slot_idx_t'(0) : probe + 1'b1;
            if (!slot_busy[probe]) begin
              slot_busy[probe]   = 1'b1;
              slot_handle[probe] = r.payload;
              grant_ptr          = probe;
              granted            = 1'b1;
            end
          end
        end
        if (granted) begin
          due_words.push_back('{probe, '0, 1'b0, 1'b0, 1'b1});
        end else begin
          due_words.push_back('{ID_INVALID_OUT, '0, 1'b0, 1'b1, 1'b1});
        end
      end
      KIND_DETACH, KIND_EXIST: begin
        if (r.task_id < ID_INVALID && slot_busy[r.task_id]) begin
          due_words.push_back('{r.task_id, slot_handle[r.task_id], 1'b1, 1'b0, 1'b1});
          if (r.kind == KIND_DETACH) begin
            slot_busy[r.task_id] = 1'b0;
          end
        end else begin
          due_words.push_back('{r.task_id, '0, 1'b0, 1'b0, 1'b1});
        end
      end
      default: begin
        live = 0;
        for (int i = 0; i < ID_SLOTS - 1; i++) begin
          live += slot_busy[i];
        end
        if (live == 0) begin
          due_words.push_back('{ID_INVALID_OUT, '0, 1'b0, 1'b0, 1'b1});
        end else begin
          // ascending order, last flag on the final entry
          emitted = 0;
          for (int i = 0; i < ID_SLOTS - 1; i++) begin
            if (slot_busy[i]) begin
              emitted++;
              due_words.push_back('{6'(i), slot_handle[i], 1'b1, 1'b0, emitted == live});
              slot_busy[i] = 1'b0;
            end
          end
        end
      end
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin : feed
    tag_req_t nxt;
    int       live_cnt;
    int       pick_k;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_to_tag_table(on_bus);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // word still waiting, keep it on the bus
      end else if (pending_reqs.size() > 0
                   && !(pending_reqs[0].drain && due_words.size() > 0)
                   && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_reqs.pop_front();
        // aim at a live slot as the table stands now
        live_cnt = 0;
        for (int i = 0; i < ID_SLOTS; i++) begin
          live_cnt += slot_busy[i];
        end
        if (nxt.aim && live_cnt > 0) begin
          pick_k = $urandom_range(live_cnt - 1);
          for (int i = 0; i < ID_SLOTS; i++) begin
            if (slot_busy[i]) begin
              if (pick_k == 0) begin
                nxt.task_id = 6'(i);
              end
              pick_k--;
            end
          end
        end
        on_bus             = nxt;
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= nxt.kind;
        in_ch.task_id     <= nxt.task_id;
        in_ch.payload_in  <= nxt.payload;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : observe
    tag_resp_t exp_w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_words.size() == 0) begin
          if (mismatch_cnt < 10) begin
            $display("unexpected word: id %0d payload %h found %b full %b last %b",
                     out_ch.id_out, out_ch.payload_out, out_ch.found, out_ch.full_res,
                     out_ch.last);
          end
          mismatch_cnt++;
        end else begin
          exp_w = due_words.pop_front();
          if (out_ch.id_out !== exp_w.id || out_ch.payload_out !== exp_w.payload
              || out_ch.found !== exp_w.found || out_ch.full_res !== exp_w.full
              || out_ch.last !== exp_w.last) begin
            if (mismatch_cnt < 10) begin
              $display("mismatch: id %0d/%0d payload %h/%h found %b/%b full %b/%b last %b/%b",
                       exp_w.id, out_ch.id_out, exp_w.payload, out_ch.payload_out,
                       exp_w.found, out_ch.found, exp_w.full, out_ch.full_res,
                       exp_w.last, out_ch.last);
            end
            mismatch_cnt++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("rotating_id_allocator_unit regression: fail");
      $finish;
    end
  end

  task automatic queue_req(input kind_t k, input logic [5:0] id, input logic [31:0] pay,
                           input bit aim = 1'b0, input bit drain = 1'b0);
    pending_reqs.push_back('{k, id, pay, aim, drain});
  endtask

  // mostly random handles, with the all-zero and all-one corners mixed in
  function automatic logic [31:0] any_payload();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // stimulus and end of run
  initial begin : stimulus
    int n;
    int fill_at;
    int r;
    bit filled;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_ATTACH;
    in_ch.task_id     = '0;
    in_ch.payload_in  = '0;
    out_ch.ready      = 1'b0;
    send_idle_pct     = 32;
    recv_stall_pct    = 48;

    // directed: empty table, missing and reserved ids, first grants
    queue_req(KIND_DETACH_ALL, 6'd17, any_payload());
    queue_req(KIND_DETACH, 6'd5, any_payload());
    queue_req(KIND_EXIST, ID_INVALID_OUT, any_payload());
    queue_req(KIND_DETACH, ID_INVALID_OUT, any_payload());
    queue_req(KIND_ATTACH, 6'd63, 32'h0000_0000);
    queue_req(KIND_ATTACH, 6'd0, 32'hFFFF_FFFF);
    queue_req(KIND_ATTACH, 6'd42, 32'hA5A5_5A5A);
    queue_req(KIND_EXIST, 6'd1, any_payload());
    queue_req(KIND_EXIST, 6'd2, any_payload());
    queue_req(KIND_DETACH, 6'd2, any_payload());
    queue_req(KIND_DETACH, 6'd2, any_payload());
    queue_req(KIND_EXIST, 6'd2, any_payload());
    queue_req(KIND_ATTACH, 6'd21, 32'h1234_5678);
    queue_req(KIND_EXIST, 6'd0, any_payload());
    queue_req(KIND_DETACH_ALL, 6'd63, any_payload());
    queue_req(KIND_DETACH_ALL, 6'd0, any_payload(), 1'b0, 1'b1);
    queue_req(KIND_ATTACH, 6'($urandom_range(63)), any_payload(), 1'b0, 1'b1);
    queue_req(KIND_DETACH, 6'd5, any_payload());
    queue_req(KIND_EXIST, 6'd62, any_payload());

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 3; ph++) begin
      while (pending_reqs.size() != 0 || in_ch.valid) @(negedge clk);
      // idle mix per phase
      case (ph)
        0: begin send_idle_pct = 32; recv_stall_pct = 48; end
        1: begin send_idle_pct = 48; recv_stall_pct = 32; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      n       = 0;
      filled  = 1'b0;
      fill_at = $urandom_range(40);
      while (n < PHASE_ITEMS) begin
        if (!filled && n >= fill_at) begin
          // run the table into full and past it, cursor wraps on the way
          for (int j = 0; j < ID_SLOTS; j++) begin
            queue_req(KIND_ATTACH, 6'($urandom_range(63)), any_payload());
          end
          filled = 1'b1;
          n += ID_SLOTS;
        end else begin
          r = $urandom_range(99);
          if (r < 35) begin
            queue_req(KIND_ATTACH, 6'($urandom_range(63)), any_payload());
          end else if (r < 60) begin
            queue_req(KIND_DETACH, 6'($urandom_range(63)), any_payload(),
                      $urandom_range(9) != 0);
          end else if (r < 85) begin
            queue_req(KIND_EXIST, 6'($urandom_range(63)), any_payload(),
                      $urandom_range(9) != 0, $urandom_range(19) == 0);
          end else if (r < 92) begin
            queue_req(KIND_DETACH_ALL, 6'($urandom_range(63)), any_payload(), 1'b0,
                      1'($urandom_range(1)));
          end else begin
            // noise: any kind, any id
            queue_req(kind_t'($urandom_range(3)), 6'($urandom_range(63)), any_payload());
          end
          n++;
        end
      end
    end

    while (pending_reqs.size() != 0 || in_ch.valid || due_words.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_cnt == 0 && due_words.size() == 0) begin
      $display("rotating_id_allocator_unit regression: pass");
    end else begin
      $display("rotating_id_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule
